>>> src/bhx_pkg.sv
`timescale 1ns / 1ps

package bhx_pkg;

  localparam int BUFFERS     = 16;
  localparam int PTR_W       = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int LEVEL_W     = $clog2(BUFFERS + 1);
  localparam int HANDLE_W    = 4;
  localparam int LEVEL_OUT_W = 5;
  localparam int COUNT_W     = 16;
  localparam int FUNC_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TAKE_EMPTY = 2'd0,
    FUNC_POST_FULL  = 2'd1,
    FUNC_TAKE_FULL  = 2'd2,
    FUNC_RELEASE    = 2'd3
  } func_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } bhx_cmd_t;

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(BUFFERS - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    if (c == {COUNT_W{1'b1}}) begin
      r = c;
    end else begin
      r = c + COUNT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> src/buffer_handle_exchange.sv
`timescale 1ns / 1ps

// channel   handshake             payload
// input     in_valid / in_ready   func, handle
// output    out_valid / out_ready out_handle, ok, free_count, ready_count,
//                                 underflow_count, post_overflow_count,
//                                 release_overflow_count
//
// each word is latched first, then the fifo pop or push and counter update
// step runs and loads the result register
// a new word is taken while the previous result still waits in that register
// rst is synchronous: free fifo refilled with handles 0..15, counters cleared
// a stalled output holds the update step until the result register frees

module buffer_handle_exchange
  import bhx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FUNC_W-1:0]      func,
  input  logic [HANDLE_W-1:0]    handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HANDLE_W-1:0]    out_handle,
  output logic                   ok,
  output logic [LEVEL_OUT_W-1:0] free_count,
  output logic [LEVEL_OUT_W-1:0] ready_count,
  output logic [COUNT_W-1:0]     underflow_count,
  output logic [COUNT_W-1:0]     post_overflow_count,
  output logic [COUNT_W-1:0]     release_overflow_count
);

  bhx_cmd_t cmd;

  bhx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bhx_dp u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .func                   (func),
    .handle                 (handle),
    .out_handle             (out_handle),
    .ok                     (ok),
    .free_count             (free_count),
    .ready_count            (ready_count),
    .underflow_count        (underflow_count),
    .post_overflow_count    (post_overflow_count),
    .release_overflow_count (release_overflow_count)
  );

endmodule

>>> src/bhx_ctrl.sv
`timescale 1ns / 1ps

module bhx_ctrl
  import bhx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bhx_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  // the result register must be free or draining this cycle
  assign cmd.exec = (state == ST_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.exec) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/bhx_dp.sv
`timescale 1ns / 1ps

module bhx_dp
  import bhx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  bhx_cmd_t               cmd,
  input  logic [FUNC_W-1:0]      func,
  input  logic [HANDLE_W-1:0]    handle,
  output logic [HANDLE_W-1:0]    out_handle,
  output logic                   ok,
  output logic [LEVEL_OUT_W-1:0] free_count,
  output logic [LEVEL_OUT_W-1:0] ready_count,
  output logic [COUNT_W-1:0]     underflow_count,
  output logic [COUNT_W-1:0]     post_overflow_count,
  output logic [COUNT_W-1:0]     release_overflow_count
);

  func_t               func_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [HANDLE_W-1:0] free_store [BUFFERS];
  logic [HANDLE_W-1:0] ready_store [BUFFERS];
  logic [PTR_W-1:0]    free_head;
  logic [PTR_W-1:0]    free_tail;
  logic [LEVEL_W-1:0]  free_level;
  logic [PTR_W-1:0]    ready_head;
  logic [PTR_W-1:0]    ready_tail;
  logic [LEVEL_W-1:0]  ready_level;
  logic [COUNT_W-1:0]  underflows;
  logic [COUNT_W-1:0]  post_overflows;
  logic [COUNT_W-1:0]  release_overflows;
  logic [HANDLE_W-1:0] result_handle;
  logic                result_ok;

  logic free_empty;
  logic free_full;
  logic ready_empty;
  logic ready_full;

  assign free_empty  = (free_level == '0);
  assign free_full   = (free_level == LEVEL_W'(BUFFERS));
  assign ready_empty = (ready_level == '0);
  assign ready_full  = (ready_level == LEVEL_W'(BUFFERS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func_t'(func);
      handle_q <= handle;
    end
  end

  // ready entries hold nothing meaningful until pushed
  always_ff @(posedge clk) begin
    if (cmd.exec && func_q == FUNC_POST_FULL && !ready_full) begin
      ready_store[ready_tail] <= handle_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUFFERS; i++) begin
        free_store[i] <= HANDLE_W'(i);
      end
      free_head         <= '0;
      free_tail         <= '0;
      free_level        <= LEVEL_W'(BUFFERS);
      ready_head        <= '0;
      ready_tail        <= '0;
      ready_level       <= '0;
      underflows        <= '0;
      post_overflows    <= '0;
      release_overflows <= '0;
      result_handle     <= '0;
      result_ok         <= 1'b0;
    end else if (cmd.exec) begin
      result_handle <= '0;
      result_ok     <= 1'b0;
      case (func_q)
        FUNC_TAKE_EMPTY: begin
          if (free_empty) begin
            underflows <= sat_inc(underflows);
          end else begin
            result_handle <= free_store[free_head];
            result_ok     <= 1'b1;
            free_head     <= wrap_ptr(free_head);
            free_level    <= free_level - LEVEL_W'(1);
          end
        end
        FUNC_POST_FULL: begin
          if (ready_full) begin
            post_overflows <= sat_inc(post_overflows);
          end else begin
            result_ok   <= 1'b1;
            ready_tail  <= wrap_ptr(ready_tail);
            ready_level <= ready_level + LEVEL_W'(1);
          end
        end
        FUNC_TAKE_FULL: begin
          if (!ready_empty) begin
            result_handle <= ready_store[ready_head];
            result_ok     <= 1'b1;
            ready_head    <= wrap_ptr(ready_head);
            ready_level   <= ready_level - LEVEL_W'(1);
          end
        end
        default: begin
          if (free_full) begin
            release_overflows <= sat_inc(release_overflows);
          end else begin
            free_store[free_tail] <= handle_q;
            result_ok             <= 1'b1;
            free_tail             <= wrap_ptr(free_tail);
            free_level            <= free_level + LEVEL_W'(1);
          end
        end
      endcase
    end
  end

  assign out_handle             = result_handle;
  assign ok                     = result_ok;
  assign free_count             = LEVEL_OUT_W'(free_level);
  assign ready_count            = LEVEL_OUT_W'(ready_level);
  assign underflow_count        = underflows;
  assign post_overflow_count    = post_overflows;
  assign release_overflow_count = release_overflows;

endmodule

>>> src/bhx_checker.sv
`timescale 1ns / 1ps

module bhx_checker
  import bhx_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [HANDLE_W-1:0]    out_handle,
  input logic                   ok,
  input logic [LEVEL_OUT_W-1:0] free_count,
  input logic [LEVEL_OUT_W-1:0] ready_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_handle) && $stable(ok))
    else $error("result word changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> out_handle == '0)
    else $error("refused operation returned a handle");

  a_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_count <= LEVEL_OUT_W'(BUFFERS) && ready_count <= LEVEL_OUT_W'(BUFFERS))
    else $error("fifo level beyond buffer count");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present straight after reset");

endmodule

bind buffer_handle_exchange bhx_checker u_bhx_checker (.*);
